@@ rtl/core/wilder_running_average_defines.svh @@
// Assertion macros for the port checker file of the running average block.
// No dependencies.
`ifndef WILDER_RUNNING_AVERAGE_DEFINES_SVH
`define WILDER_RUNNING_AVERAGE_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define WRA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define WRA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/wra_pkg.sv @@
// Package for the Wilder running average: widths, constants, codes and the
// controller/datapath interface structs. No dependencies.
package wra_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int MAX_PERIOD  = 4096;
    localparam int PERIOD_W    = 13;
    localparam int SUM_W       = 44;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(SUM_W);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);
    localparam logic                REG_PERIOD   = 1'b0;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SEED,
        MODE_UPDATE
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SIGN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic sign;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

@@ rtl/core/wra_divider.sv @@
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on wra_pkg.
module wra_divider
    import wra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic [SUM_W-1:0]    quotient,
    output logic                done
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quot_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [PERIOD_W-1:0]  div_reg;
    logic [PERIOD_W:0]    shifted;
    logic [PERIOD_W:0]    trial;
    logic                 fits;

    assign shifted = {rem_reg, quot_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
            rem_reg  <= fits ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/wra_datapath.sv @@
// Datapath: period register, seed sum, smoothed value, divider and output word.
// Depends on wra_pkg and wra_divider.
module wra_datapath
    import wra_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic                          cfg_we,
    input  logic [PERIOD_W-1:0]           cfg_wdata,
    output logic [PERIOD_W-1:0]           period,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic                          valid_res
);

    logic [PERIOD_W-1:0]           period_reg;
    logic [PERIOD_W-1:0]           seen_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    mode_t                         mode_reg;
    mode_t                         mode_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic signed [DIFF_W-1:0]      q_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg;
    logic                          out_vres_reg;

    logic [PERIOD_W-1:0]           eff_p;
    logic [PERIOD_W-1:0]           seen_inc;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [DIFF_W-1:0]      diff;
    logic [SUM_W-1:0]              dividend;
    logic [SUM_W-1:0]              quotient;
    logic                          div_done;
    logic [DIFF_W-1:0]             q_mag;
    logic signed [DIFF_W-1:0]      y_sum;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          seeded;

    always_comb
    begin
        if (period_reg == '0)
            eff_p = PERIOD_W'(1);
        else if (period_reg > PERIOD_W'(MAX_PERIOD))
            eff_p = PERIOD_W'(MAX_PERIOD);
        else
            eff_p = period_reg;
    end

    assign seeded   = seen_reg >= eff_p;
    assign seen_inc = seen_reg + 1'b1;
    assign sum_next = sum_reg + {{(SUM_W-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
    assign diff     = {x_reg[SAMPLE_BITS-1], x_reg} - {y_reg[SAMPLE_BITS-1], y_reg};

    always_comb
    begin
        dividend  = '0;
        mode_next = MODE_NONE;
        neg_next  = 1'b0;
        if (seeded)
        begin
            mode_next = MODE_UPDATE;
            neg_next  = diff[DIFF_W-1];
            dividend  = SUM_W'(diff[DIFF_W-1] ? -diff : diff);
        end
        else if (seen_inc == eff_p)
        begin
            mode_next = MODE_SEED;
            neg_next  = sum_next[SUM_W-1];
            dividend  = sum_next[SUM_W-1] ? -sum_next : sum_next;
        end
    end

    wra_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.prep && (mode_next != MODE_NONE)),
        .dividend (dividend),
        .divisor  (eff_p),
        .quotient (quotient),
        .done     (div_done)
    );

    assign q_mag  = quotient[DIFF_W-1:0];
    assign y_sum  = {y_reg[SAMPLE_BITS-1], y_reg} + q_reg;
    assign y_next = (mode_reg == MODE_UPDATE) ? y_sum[SAMPLE_BITS-1:0]
                                              : q_reg[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            seen_reg      <= '0;
            sum_reg       <= '0;
            y_reg         <= '0;
            mode_reg      <= MODE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
                seen_reg   <= '0;
                sum_reg    <= '0;
                y_reg      <= '0;
            end
            else if (cmd.prep)
            begin
                mode_reg <= mode_next;
                if (!seeded)
                begin
                    seen_reg <= seen_inc;
                    sum_reg  <= sum_next;
                end
            end
            else if (cmd.write && (mode_reg != MODE_NONE))
                y_reg <= y_next;

            if (cmd.write)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= sample;
        if (cmd.prep)
            neg_reg <= neg_next;
        if (cmd.sign)
            q_reg <= neg_reg ? -q_mag : q_mag;
        if (cmd.write)
        begin
            out_avg_reg  <= (mode_reg != MODE_NONE) ? y_next : '0;
            out_vres_reg <= mode_reg != MODE_NONE;
        end
    end

    assign status.need_div = mode_next != MODE_NONE;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign period    = period_reg;
    assign out_valid = out_valid_reg;
    assign average   = out_avg_reg;
    assign valid_res = out_vres_reg;

endmodule

@@ rtl/core/wra_controller.sv @@
// Controller state machine: accept, prepare, divide and sign (only when a division is needed), write.
// Depends on wra_pkg.
module wra_controller
    import wra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.need_div ? ST_DIV : ST_WRITE;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                cmd.sign   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/wilder_running_average.sv @@
// Wilder running average (smoothed moving average), top level.
// Depends on wra_pkg, wra_controller and wra_datapath.
//
// Input stream s_*: one word per price sample, signed Q.16, oldest first.
// Output stream m_*: one word per sample; tdata is the smoothed value and
// tuser is set once period samples have been seen (tdata is zero before).
// APB port: register 0 at byte address 0 is the period (13 bits). Writing it
// restarts the seeding phase. Write only while the block is idle.
// Sequence: a sample that only adds to the seed sum goes from accept through
// the prepare and write states to the output register. A sample that needs a
// division (the seeding sample and every one after it) also passes the
// bit-serial divider, one quotient bit per cycle, and sign correction between
// prepare and writeback. One sample is in work at a time, so a new sample is
// accepted only after the last one has been written to the output register.
// The output register holds a finished word while the sink stalls; the next
// sample is already accepted and worked on, and only its writeback waits.
// Reset clears the count, sum and smoothed value and sets the period to 20.
module wilder_running_average
    import wra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,   // [31:0] sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_BITS-1:0] m_tdata,   // [31:0] average
    output logic                   m_tuser,   // [0] valid_res
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    cmd_t                cmd;
    status_t             status;
    logic                cfg_we;
    logic [PERIOD_W-1:0] period;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_PERIOD);
    assign prdata = (paddr[PADDR_W-1] == REG_PERIOD) ? PDATA_W'(period) : '0;

    wra_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wra_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[PERIOD_W-1:0]),
        .period    (period),
        .sample    (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .average   (m_tdata),
        .valid_res (m_tuser)
    );

endmodule

@@ rtl/core/wra_checker.sv @@
// Port-level checks for the running average top level, bound to it below.
// Depends on wra_pkg and wilder_running_average_defines.svh.
`include "wilder_running_average_defines.svh"

module wra_port_checks
    import wra_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [SAMPLE_BITS-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   pready
);

    `WRA_ASSERT_ALWAYS(a_no_out_in_reset, clk, !rst_n |=> !m_tvalid, "output word during reset")
    `WRA_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")
    `WRA_ASSERT(a_zero_before_valid, clk, rst_n, m_tvalid && !m_tuser |-> m_tdata == '0, "average not zero before seeding")
    `WRA_ASSERT(a_one_in_work, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "second word taken while busy")
    `WRA_ASSERT(a_pready_high, clk, rst_n, pready, "pready dropped")

endmodule

bind wilder_running_average wra_port_checks u_chk (.*);

@@ sim/wra_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for wilder_running_average: follows the APB port and both streams,
// predicts every output word and compares it with what the block sends.
// Depends on wra_pkg.
module wra_checker
    import wra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,   // [31:0] sample
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [SAMPLE_BITS-1:0] m_tdata,   // [31:0] average
    input  logic                   m_tuser,   // [0] valid_res
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic [PDATA_W-1:0]     prdata,
    input  logic                   pready,
    output int                     pending,
    output int                     fails
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   valid_res;
    } avg_word_t;

    avg_word_t                     expected_avg_q[$];
    logic [PERIOD_W-1:0]           period_q;
    int                            seen_q;
    longint                        seed_sum_q;
    logic signed [SAMPLE_BITS-1:0] level_q;
    int                            fail_count;

    function automatic void clear_average();
        seen_q     = 0;
        seed_sum_q = 0;
        level_q    = '0;
    endfunction

    // Seed with the truncated mean, then y += (x - y) / N, also truncated.
    function automatic avg_word_t smooth_step(input logic signed [SAMPLE_BITS-1:0] x);
        longint    eff;
        longint    diff;
        avg_word_t w;
        eff = longint'(period_q);
        if (eff == 0)
            eff = 1;
        if (eff > MAX_PERIOD)
            eff = MAX_PERIOD;
        w.valid_res = 1'b0;
        if (longint'(seen_q) >= eff)
        begin
            diff        = longint'(x) - longint'(level_q);
            level_q     = SAMPLE_BITS'(longint'(level_q) + diff / eff);
            w.valid_res = 1'b1;
        end
        else
        begin
            seed_sum_q += longint'(x);
            seen_q++;
            if (longint'(seen_q) == eff)
            begin
                level_q     = SAMPLE_BITS'(seed_sum_q / eff);
                w.valid_res = 1'b1;
            end
        end
        w.average = w.valid_res ? level_q : '0;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_word_t got;
        avg_word_t want;
        if (!rst_n)
        begin
            period_q = PERIOD_RESET;
            clear_average();
            expected_avg_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.average   = m_tdata;
                got.valid_res = m_tuser;
                if (expected_avg_q.size() == 0)
                begin
                    $error("output word with no sample outstanding: average %h valid_res %b",
                           got.average, got.valid_res);
                    fail_count++;
                end
                else
                begin
                    want = expected_avg_q.pop_front();
                    if (got.average !== want.average)
                    begin
                        $error("average: expected %h, actual %h", want.average, got.average);
                        fail_count++;
                    end
                    if (got.valid_res !== want.valid_res)
                    begin
                        $error("valid_res: expected %b, actual %b",
                               want.valid_res, got.valid_res);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_PERIOD)
            begin
                if (pwrite)
                begin
                    period_q = pwdata[PERIOD_W-1:0];
                    clear_average();
                end
                else if (prdata !== PDATA_W'(period_q))
                begin
                    $error("period: expected %h, actual %h", PDATA_W'(period_q), prdata);
                    fail_count++;
                end
            end
            if (s_tvalid && s_tready)
                expected_avg_q.push_back(smooth_step(s_tdata));
        end
        pending <= expected_avg_q.size();
        fails   <= fail_count;
    end

endmodule

@@ sim/wilder_running_average_tb.sv @@
`timescale 1ns / 100ps
// Top of the wilder_running_average testbench: clock, reset, APB writes, sample
// stimulus and output back-pressure. Checking lives in wra_checker; needs wra_pkg.
module wilder_running_average_tb;
    import wra_pkg::*;

    localparam int WATCHDOG_LIMIT        = 5000;
    localparam int HOLD_CYCLES           = 400;
    localparam int DRAIN_CYCLES          = 60;
    localparam int RANDOM_ITEMS_PER_MODE = 300;

    localparam logic [PADDR_W-1:0]     ADDR_PERIOD = PADDR_W'({REG_PERIOD, 2'b00});
    localparam logic [PADDR_W-1:0]     ADDR_SPARE  = PADDR_W'(4);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN  = 32'h8000_0000;
    localparam logic [SAMPLE_BITS-1:0] Q16_ONE     = 32'h0001_0000;
    localparam logic [SAMPLE_BITS-1:0] MINUS_ONE   = 32'hFFFF_FFFF;
    localparam int                     PERIOD_ALL_ONES = (1 << PERIOD_W) - 1;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata  = '0;        // [31:0] sample
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [SAMPLE_BITS-1:0] m_tdata;              // [31:0] average
    logic                   m_tuser;              // [0] valid_res
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    int                     pending;
    int                     fails;

    int                     src_idle_pct    = 17;
    int                     snk_idle_pct    = 70;
    int                     hold_req_count  = 0;
    int                     hold_seen_count = 0;
    int                     hold_left       = 0;
    int                     quiet_cycles    = 0;
    logic [SAMPLE_BITS-1:0] price_base      = 32'h0064_0000;

    wilder_running_average i_dut (.*);

    wra_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sink: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen_count != hold_req_count)
        begin
            hold_seen_count <= hold_req_count;
            hold_left       <= HOLD_CYCLES;
            m_tready        <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("wilder_running_average_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Write a register, then read the period back for the checker.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        apb_access(1'b1, addr, data);
        apb_access(1'b0, ADDR_PERIOD, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_burst(input logic [SAMPLE_BITS-1:0] words[$]);
        foreach (words[i])
            send_sample(words[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned            sel;
        logic [SAMPLE_BITS-1:0] noise;
        sel   = $urandom_range(99);
        noise = $urandom_range(32'h3_FFFF) - 32'h2_0000;
        if (sel < 50)
            return price_base + noise;
        if (sel < 80)
            return $urandom;
        if (sel < 90)
            return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        return $urandom_range(2) - 1;
    endfunction

    task automatic random_phase(output int sent);
        int sel;
        int p;
        int n;
        sel = $urandom_range(99);
        if (sel < 70)
            p = $urandom_range(24, 1);
        else if (sel < 80)
            p = 0;
        else if (sel < 92)
            p = $urandom_range(200, 25);
        else
            p = $urandom_range(PERIOD_ALL_ONES, MAX_PERIOD + 1);
        if (sel >= 92)
            n = $urandom_range(30, 5);
        else
            n = ((p == 0) ? 1 : p) + $urandom_range(40, 3);
        if ($urandom_range(99) < 20)
            price_base = $urandom;
        else
            price_base = $urandom_range(32'h1388_0000, 32'h0001_0000);
        drain();
        write_reg(ADDR_PERIOD, PDATA_W'(p));
        repeat (n)
            send_sample(pick_sample());
        sent = n;
    endtask

    initial
    begin
        int random_sent;
        int phase_items;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset period, unused register ignored
        write_reg(ADDR_SPARE, $urandom);
        send_burst('{SAMPLE_MAX, SAMPLE_MIN, Q16_ONE});
        drain();
        write_reg(ADDR_PERIOD, 1);
        send_burst('{SAMPLE_MAX, SAMPLE_MIN, '0, MINUS_ONE, 32'd1, Q16_ONE});
        drain();
        write_reg(ADDR_PERIOD, 0);
        send_burst('{SAMPLE_MIN, SAMPLE_MAX});
        drain();
        write_reg(ADDR_PERIOD, 3);
        send_burst('{MINUS_ONE, MINUS_ONE});
        drain();
        write_reg(ADDR_SPARE, $urandom);
        send_burst('{'0, -32'sd7, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 32'd5});
        drain();
        write_reg(ADDR_PERIOD, 2);
        send_burst('{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX});

        // oversized period stays unseeded; then a seed from a run at full scale
        drain();
        write_reg(ADDR_PERIOD, PERIOD_ALL_ONES);
        repeat (24)
            send_sample(SAMPLE_MIN);
        drain();
        write_reg(ADDR_PERIOD, 64);
        repeat (64)
            send_sample(SAMPLE_MAX);
        repeat (4)
            send_sample(SAMPLE_MIN);

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    src_idle_pct = 17;
                    snk_idle_pct = 70;
                end
                1:
                begin
                    src_idle_pct = 70;
                    snk_idle_pct = 17;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            random_sent = 0;
            while (random_sent < RANDOM_ITEMS_PER_MODE)
            begin
                random_phase(phase_items);
                random_sent += phase_items;
            end
        end

        // sink holds off while samples keep coming
        drain();
        write_reg(ADDR_PERIOD, 1);
        hold_req_count++;
        repeat (30)
            send_sample(pick_sample());

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("wilder_running_average_tb passed");
        else
            $display("wilder_running_average_tb failed");
        $finish;
    end

endmodule
